>>> design/hsm_pkg.sv
`timescale 1ns / 1ps
package hsm_pkg;
  localparam int NODE_BITS  = 12;
  localparam int NODE_COUNT = 4096;
  localparam int VAL_BITS   = 32;
  localparam int COL_BITS   = 10;
  localparam int ROW_DEPTH  = 1024;
  localparam int GRID_BITS  = 11;
  localparam int DIM_BITS   = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                 is_pixel;
    logic [NODE_BITS-1:0] node;
    logic [NODE_BITS-1:0] parent;
    logic [VAL_BITS-1:0]  value;
    logic [COL_BITS-1:0]  x;
    logic [COL_BITS-1:0]  y;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_RD, ST_LOAD_WR, ST_FETCH, ST_CLIMB_RD, ST_CLIMB_CMP,
    ST_VAL_RD, ST_VAL_WAIT, ST_EMIT
  } state_t;
endpackage

>>> design/hsm_front.sv
`timescale 1ns / 1ps
module hsm_front import hsm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,
  input  logic                in_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data,
  output logic                q_valid,
  input  logic                q_ready,
  output job_t                q_job
);
  logic [DIM_BITS-1:0] width_r, height_r;
  logic [COL_BITS-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [COL_BITS:0]   w_eff, h_eff;
  job_t q_r [QUEUE_DEPTH];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push, pop;
  job_t       job;

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = q_r[rp_r];

  always_comb begin
    w_eff = (width_r == '0) ? (COL_BITS+1)'(1) :
            (width_r > DIM_BITS'(ROW_DEPTH)) ? (COL_BITS+1)'(ROW_DEPTH) : width_r;
    h_eff = (height_r == '0) ? (COL_BITS+1)'(1) :
            (height_r > DIM_BITS'(ROW_DEPTH)) ? (COL_BITS+1)'(ROW_DEPTH) : height_r;
    job.is_pixel = in_tuser;
    // pixel beats carry their label in the pixel_node field
    job.node     = (in_tuser == CMD_PIXEL) ? in_tdata[67:56] : in_tdata[11:0];
    job.parent   = in_tdata[23:12];
    job.value    = in_tdata[55:24];
    job.x        = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    job.y        = ({1'b0, row_r} >= h_eff) ? '0 : row_r;
    col_nxt = job.x + 1'b1;
    row_nxt = job.y;
    if ({1'b0, job.x} + 1'b1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = ({1'b0, job.y} + 1'b1 >= h_eff) ? '0 : job.y + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (!rst_n) begin
      width_r <= DIM_BITS'(ROW_DEPTH);
      height_r <= DIM_BITS'(ROW_DEPTH);
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (cfg_valid) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
        col_r <= '0;
        row_r <= '0;
      end else if (push && in_tuser == CMD_PIXEL) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end
endmodule

>>> design/hsm_back.sv
`timescale 1ns / 1ps
module hsm_back import hsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  job_t                 q_job,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  output logic                 out_tlast
);
  logic [NODE_BITS-1:0] parent_mem [NODE_COUNT];
  logic [NODE_BITS-1:0] depth_mem  [NODE_COUNT];
  logic [VAL_BITS-1:0]  value_mem  [NODE_COUNT];
  logic [NODE_BITS-1:0] up_node_mem  [ROW_DEPTH];
  logic [VAL_BITS-1:0]  up_hedge_mem [ROW_DEPTH];

  state_t state_r, state_nxt;
  job_t   job_r;
  logic [NODE_BITS-1:0] a_r, b_r, pa_r, pb_r, da_r, db_r, pd_r, up_node_r;
  logic [VAL_BITS-1:0]  val_r, up_hedge_r, hedge_r, vedge_r, left_vedge_r;
  logic [NODE_BITS-1:0] left_node_r;
  logic [NODE_BITS:0]   steps_r;
  logic                 pass_r;  // 0: left climb, 1: upper climb
  logic [1:0]           k_r;     // next result: 0 h, 1 v, 2 corner, 3 point
  logic                 ov_r;
  logic [55:0]          od_r;
  logic                 ol_r;
  logic                 go_climb;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign q_ready    = (state_r == ST_IDLE);

  function automatic logic [VAL_BITS-1:0] smax(input logic [VAL_BITS-1:0] p,
                                               input logic [VAL_BITS-1:0] q);
    smax = ($signed(p) > $signed(q)) ? p : q;
  endfunction

  always_comb begin
    state_nxt = state_r;
    go_climb = (a_r == b_r) || steps_r[NODE_BITS];
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = q_job.is_pixel ? ST_FETCH : ST_LOAD_RD;
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: state_nxt = ST_IDLE;
      ST_FETCH: begin
        // first column has no left neighbor: go straight to the upper climb (emit if y is 0)
        if (job_r.x == '0) state_nxt = (job_r.y == '0) ? ST_EMIT : ST_VAL_WAIT;
        else state_nxt = ST_CLIMB_RD;
      end
      ST_CLIMB_RD: state_nxt = go_climb ? ST_VAL_RD : ST_CLIMB_CMP;
      ST_CLIMB_CMP: state_nxt = ST_CLIMB_RD;
      ST_VAL_RD: state_nxt = ST_VAL_WAIT;
      ST_VAL_WAIT: state_nxt = (!pass_r && job_r.y != '0) ? ST_CLIMB_RD : ST_EMIT;
      ST_EMIT: if (!ov_r || out_tready) state_nxt = (k_r == 2'd3) ? ST_IDLE : ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // memories
    if (state_r == ST_LOAD_RD) pd_r <= depth_mem[job_r.parent];
    if (state_r == ST_LOAD_WR) begin
      parent_mem[job_r.node] <= (job_r.node == '0) ? '0 : job_r.parent;
      depth_mem[job_r.node]  <= (job_r.node == '0) ? '0 : pd_r + 1'b1;
      value_mem[job_r.node]  <= job_r.value;
    end
    if (state_r == ST_FETCH) begin
      up_node_r  <= up_node_mem[job_r.x];
      up_hedge_r <= up_hedge_mem[job_r.x];
    end
    if (state_r == ST_CLIMB_RD) begin
      da_r <= depth_mem[a_r];
      db_r <= depth_mem[b_r];
      pa_r <= parent_mem[a_r];
      pb_r <= parent_mem[b_r];
    end
    // an exhausted climb that never met falls back to the root
    if (state_r == ST_VAL_RD) val_r <= value_mem[(a_r == b_r) ? a_r : '0];
    if (state_r == ST_EMIT && k_r == 2'd3 && (!ov_r || out_tready)) begin
      up_node_mem[job_r.x]  <= job_r.node;
      up_hedge_mem[job_r.x] <= hedge_r;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      left_node_r <= '0;
      left_vedge_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready && state_r != ST_EMIT) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (q_valid) job_r <= q_job;
        ST_FETCH: begin
          hedge_r <= '0;
          vedge_r <= '0;
          k_r <= 2'd0;
          steps_r <= '0;
          pass_r <= 1'b0;
          a_r <= left_node_r;
          b_r <= job_r.node;
        end
        ST_CLIMB_RD: begin
          if (!go_climb) steps_r <= steps_r + 1'b1;
        end
        ST_CLIMB_CMP: begin
          if (da_r >= db_r) a_r <= pa_r;
          if (db_r >= da_r) b_r <= pb_r;
        end
        ST_VAL_WAIT: begin
          steps_r <= '0;
          if (!pass_r) begin
            if (job_r.x != '0) hedge_r <= val_r;
            pass_r <= 1'b1;
            a_r <= up_node_r;
            b_r <= job_r.node;
          end else begin
            vedge_r <= val_r;
          end
        end
        ST_EMIT: if (!ov_r || out_tready) begin
          od_r[55:54] <= '0;
          case (k_r)
            2'd0: begin
              od_r[10:0]  <= {job_r.x, 1'b0} - 1'b1;
              od_r[21:11] <= {job_r.y, 1'b0};
              od_r[53:22] <= hedge_r;
              ov_r <= (job_r.x != '0);
              ol_r <= 1'b0;
            end
            2'd1: begin
              od_r[10:0]  <= {job_r.x, 1'b0};
              od_r[21:11] <= {job_r.y, 1'b0} - 1'b1;
              od_r[53:22] <= vedge_r;
              ov_r <= (job_r.y != '0);
              ol_r <= 1'b0;
            end
            2'd2: begin
              od_r[10:0]  <= {job_r.x, 1'b0} - 1'b1;
              od_r[21:11] <= {job_r.y, 1'b0} - 1'b1;
              od_r[53:22] <= smax(smax(smax(smax('0, up_hedge_r), left_vedge_r),
                                  hedge_r), vedge_r);
              ov_r <= (job_r.x != '0) && (job_r.y != '0);
              ol_r <= 1'b0;
            end
            default: begin
              od_r[10:0]  <= {job_r.x, 1'b0};
              od_r[21:11] <= {job_r.y, 1'b0};
              od_r[53:22] <= '0;
              ov_r <= 1'b1;
              ol_r <= 1'b1;
              left_node_r <= job_r.node;
              left_vedge_r <= vedge_r;
            end
          endcase
          k_r <= k_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> design/hierarchy_saliency_map.sv
`timescale 1ns / 1ps
// Saliency map from a component tree.
// in_*: beats with in_tuser = 0 load a tree node (parents before children);
//   in_tuser = 1 beats carry the node label of one pixel, raster order.
// out_*: grid points of the double-resolution map; out_tlast marks the
//   pixel point, the final beat of each pixel.
// cfg_*: index 0 image width, 1 image height; a write restarts the frame.
// A node load holds the back end while it reads the parent depth and writes
//   the node. A pixel holds it through one climb per neighbor (left when
//   x > 0, upper when y > 0); a climb reads parents until the nodes
//   meet, so the rate follows tree depth. The four result slots are each
//   stepped through in turn even when a point is skipped.
// A two-entry queue lets the front accept beats while the back works.
// Reset sets width and height to 1024 and the frame to (0, 0); node and row
//   memories are not cleared. A stalled out_tready holds the output register
//   and the back stops; the front keeps accepting until its queue fills.
module hierarchy_saliency_map import hsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // node_index, parent_index, node_value, pixel_node
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // grid_x, grid_y, saliency
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  logic q_valid, q_ready;
  job_t q_job;

  hsm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_job
  );
  hsm_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast
  );
endmodule
